### rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants of the pixel tone mapper
// Pixel structs, per-channel divider lane state and curve constants.
// ----------------------------------------------------------------------------
package ptm_pkg;

   localparam int NumChannels = 3;
   localparam int QuoBits     = 9;   // one quotient bit per divider cell
   localparam int NumCells    = QuoBits;
   localparam int NumBits     = 32;  // dividend width
   localparam int DenBits     = 25;  // divisor width
   localparam int DvBits      = DenBits + QuoBits - 1;

   localparam logic CurveReinhard = 1'b0;
   localparam logic CurveAces     = 1'b1;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_pixel_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_pixel_type;

   typedef struct packed {
      logic [NumBits-1:0] rem;
      logic [DvBits-1:0]  dv;
      logic [QuoBits-1:0] quo;
   } lane_type;

   typedef lane_type [NumChannels-1:0] lanes_type;

endpackage

### rtl/ptm_front.sv
// ----------------------------------------------------------------------------
// ptm_front: dividend and divisor preparation
// Two registered stages build the curve's numerator and aligned divisor.
// ----------------------------------------------------------------------------
module ptm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  ptm_pkg::req_pixel_type in_pixel,
   input  logic                   curve_mode,
   output logic                   out_valid,
   output ptm_pkg::lanes_type     out_lanes
);

   logic [7:0]  x_ff [ptm_pkg::NumChannels];
   logic [15:0] t1_ff [ptm_pkg::NumChannels];
   logic [16:0] t2_ff [ptm_pkg::NumChannels];
   logic        v1_ff, v2_ff;
   ptm_pkg::lanes_type lanes_ff, lanes_in;
   logic [7:0]  x_in [ptm_pkg::NumChannels];

   assign x_in[0] = in_pixel.red_in;
   assign x_in[1] = in_pixel.green_in;
   assign x_in[2] = in_pixel.blue_in;

   always_comb begin
      logic [23:0] prod;
      logic [24:0] dprod;
      logic [ptm_pkg::NumBits-1:0] num;
      logic [ptm_pkg::DenBits-1:0] den;
      for (int c = 0; c < ptm_pkg::NumChannels; c++) begin
         if (curve_mode == ptm_pkg::CurveAces) begin
            prod  = 24'(x_ff[c]) * 24'(t1_ff[c]);
            num   = (32'(prod) << 8) - 32'(prod);
            dprod = 25'(x_ff[c]) * 25'(t2_ff[c]);
            den   = dprod + 25'd910350;
         end else begin
            prod  = '0;
            dprod = '0;
            num = (32'(x_ff[c]) << 8) - 32'(x_ff[c]);
            den = 25'(x_ff[c]) + 25'd255;
         end
         lanes_in[c].rem = num;
         lanes_in[c].dv  = ptm_pkg::DvBits'(den) << (ptm_pkg::QuoBits - 1);
         lanes_in[c].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < ptm_pkg::NumChannels; c++) begin
            x_ff[c]  <= x_in[c];
            t1_ff[c] <= 16'(16'd251 * 16'(x_in[c]) + 16'd765);
            t2_ff[c] <= 17'(17'd243 * 17'(x_in[c]) + 17'd15045);
         end
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_lanes = lanes_ff;

endmodule

### rtl/ptm_div_cell.sv
// ----------------------------------------------------------------------------
// ptm_div_cell: one restoring division step for all three channels
// Decides one quotient bit and hands the remainder to the next cell.
// ----------------------------------------------------------------------------
module ptm_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  ptm_pkg::lanes_type in_lanes,
   output logic               out_valid,
   output ptm_pkg::lanes_type out_lanes
);

   logic               valid_ff;
   ptm_pkg::lanes_type lanes_ff, lanes_in;

   always_comb begin
      for (int c = 0; c < ptm_pkg::NumChannels; c++) begin
         lanes_in[c].dv = in_lanes[c].dv >> 1;
         if (ptm_pkg::DvBits'(in_lanes[c].rem) >= in_lanes[c].dv) begin
            lanes_in[c].rem = in_lanes[c].rem - ptm_pkg::NumBits'(in_lanes[c].dv);
            lanes_in[c].quo = {in_lanes[c].quo[ptm_pkg::QuoBits-2:0], 1'b1};
         end else begin
            lanes_in[c].rem = in_lanes[c].rem;
            lanes_in[c].quo = {in_lanes[c].quo[ptm_pkg::QuoBits-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

endmodule

### rtl/pixel_tone_mapper.sv
// ----------------------------------------------------------------------------
// pixel_tone_mapper: per-channel Reinhard or ACES filmic tone mapping
// Maps each 8-bit channel of an RGB pixel through the selected curve.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_valid/req_ready with one RGB pixel in
// req_data; mapped pixels leave on rsp_valid/rsp_ready in rsp_data, one per
// request and in request order. The csr port writes curve_mode (0 Reinhard,
// 1 ACES filmic); it is always ready and should be written only while no
// request is in flight.
// From the accepting edge to rsp_valid, two stages build the numerator and
// divisor of the curve, then a row of nine identical divider cells each
// settles one quotient bit and passes its remainder on.
// Throughput is one pixel per clock while the receiver does not stall; every stage holds its own request.
// Reset clears all valid bits and sets curve_mode to Reinhard.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; while the last stage is empty the pipeline keeps
// moving and accepts requests even if rsp_ready is low.
// ----------------------------------------------------------------------------
module pixel_tone_mapper (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ptm_pkg::req_pixel_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptm_pkg::rsp_pixel_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   logic               mode_ff;
   logic               enable;
   logic               cell_valid [ptm_pkg::NumCells+1];
   ptm_pkg::lanes_type cell_lanes [ptm_pkg::NumCells+1];
   logic [7:0]         mapped [ptm_pkg::NumChannels];

   // The pipeline advances unless a finished result is being held back.
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ptm_pkg::CurveReinhard;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   ptm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_valid),
      .in_pixel   (req_data),
      .curve_mode (mode_ff),
      .out_valid  (cell_valid[0]),
      .out_lanes  (cell_lanes[0])
   );

   // Row of divider cells; the last cell's register is the output register.
   for (genvar k = 0; k < ptm_pkg::NumCells; k++) begin : g_cell
      ptm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (cell_valid[k]),
         .in_lanes  (cell_lanes[k]),
         .out_valid (cell_valid[k+1]),
         .out_lanes (cell_lanes[k+1])
      );
   end

   // The curves stay below 256, but the clamp matches the defined upper limit.
   always_comb begin
      for (int c = 0; c < ptm_pkg::NumChannels; c++) begin
         if (cell_lanes[ptm_pkg::NumCells][c].quo[ptm_pkg::QuoBits-1]) begin
            mapped[c] = 8'hFF;
         end else begin
            mapped[c] = cell_lanes[ptm_pkg::NumCells][c].quo[7:0];
         end
      end
   end

   assign rsp_valid          = cell_valid[ptm_pkg::NumCells];
   assign rsp_data.red_out   = mapped[0];
   assign rsp_data.green_out = mapped[1];
   assign rsp_data.blue_out  = mapped[2];

endmodule
